// ----- design/dfasu_pkg.sv -----
// shared constants for the dark frame average subtract unit
package dfasu_pkg;
   localparam int MAX_SLOTS = 20;
   localparam int PIXELS    = 2048;
   localparam int DEPTH     = MAX_SLOTS * PIXELS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int USED_W    = $clog2(MAX_SLOTS + 1);
   localparam int KEY_W     = 24;
   localparam int PIX_W     = 11;
   localparam int SAMPLE_W  = 24;
   localparam int CORR_W    = 25;
   localparam int SUM_W     = 32;
   localparam int CNT_W     = 8;
   localparam int SLOT_PORT_W = 5;
   localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ACC   = 2'd1;
   localparam logic [1:0] CMD_CORR  = 2'd2;
endpackage

// ----- design/dfasu_ram.sv -----
// generic single write port ram with registered read
module dfasu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/dfasu_div.sv -----
// bit serial signed by unsigned divider, truncating toward zero
module dfasu_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [dfasu_pkg::SUM_W-1:0] dividend,
   input  logic [dfasu_pkg::CNT_W-1:0]       divisor,
   output logic                              done,
   output logic signed [dfasu_pkg::SUM_W:0]  quotient
);
   import dfasu_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic [SUM_W-1:0]  mag_ff, mag_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic              qbit;

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, mag_ff[SUM_W-1]};
      qbit    = (trial >= {1'b0, div_ff});
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = qbit ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         mag_in  = {mag_ff[SUM_W-2:0], qbit};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
endmodule

// ----- design/dark_frame_average_subtract_unit.sv -----
// top level: dark spectrum table with averaging and subtraction
//
//  channel  | ports                                          | handshake
//  request  | req_cmd req_exposure_us req_pixel_index req_sample | start high, busy low
//  response | rsp_corrected rsp_matched rsp_slot rsp_accepted  | rsp_valid for one cycle
//  csr      | csr_wdata (enable for accumulate and correct)  | csr_we
//
// clear and unused commands respond from S_LOOK, accumulate and pass-through from S_MOD
// correct with a match goes on to S_DIV: read of the sums ram plus a 32 step serial divider
// one beat is in flight at a time; busy stays high until its response strobe
// synchronous reset empties the table; sums ram needs no clearing
// the response cannot be stalled
module dark_frame_average_subtract_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_cmd,
   input  logic [dfasu_pkg::KEY_W-1:0]         req_exposure_us,
   input  logic [dfasu_pkg::PIX_W-1:0]         req_pixel_index,
   input  logic signed [dfasu_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   output logic signed [dfasu_pkg::CORR_W-1:0] rsp_corrected,
   output logic                                rsp_matched,
   output logic [dfasu_pkg::SLOT_PORT_W-1:0]   rsp_slot,
   output logic                                rsp_accepted,
   input  logic                                csr_we,
   input  logic                                csr_wdata
);
   import dfasu_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_MOD  = 2'd2;
   localparam logic [1:0] S_DIV  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [PIX_W-1:0]    pix_ff, pix_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [KEY_W-1:0]    keys_ff [MAX_SLOTS];
   logic [KEY_W-1:0]    keys_in [MAX_SLOTS];
   logic [CNT_W-1:0]    counts_ff [MAX_SLOTS];
   logic [CNT_W-1:0]    counts_in [MAX_SLOTS];
   logic [USED_W-1:0]   used_ff, used_in;
   logic                fresh_ff, fresh_in;
   logic                enable_ff, enable_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [CORR_W-1:0] rsp_corr_ff, rsp_corr_in;
   logic                rsp_matched_ff, rsp_matched_in;
   logic [SLOT_PORT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                rsp_acc_ff, rsp_acc_in;

   logic                hit;
   logic [SLOT_W-1:0]   hit_idx;
   logic [SLOT_W-1:0]   slot_sel;
   logic [ADDR_W-1:0]   rd_addr;
   logic                pix_ok;
   logic                ram_we;
   logic [SUM_W-1:0]    ram_wdata;
   logic [SUM_W-1:0]    ram_rdata;
   logic [SUM_W-1:0]    sv;
   logic [CNT_W-1:0]    cur_count;
   logic [CNT_W-1:0]    div_count;
   logic                div_start;
   logic                div_done;
   logic signed [SUM_W:0] quotient;
   logic signed [SUM_W:0] diff;

   dfasu_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sums (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   dfasu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ($signed(ram_rdata)),
      .divisor  (div_count),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if ((USED_W'(i) < used_ff) && (keys_ff[i] == key_ff)) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
      end
   end

   assign slot_sel  = hit ? hit_idx : SLOT_W'(used_ff);
   assign rd_addr   = ADDR_W'(int'(slot_sel) * PIXELS + int'(pix_ff));
   assign pix_ok    = int'(pix_ff) < PIXELS;
   assign sv        = SUM_W'(sample_ff);
   assign cur_count = counts_ff[hit_idx_ff];
   assign div_count = (cur_count == '0) ? CNT_W'(1) : cur_count;
   assign diff      = SUM_W'(sample_ff) - quotient;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      pix_in         = pix_ff;
      sample_in      = sample_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      addr_in        = addr_ff;
      keys_in        = keys_ff;
      counts_in      = counts_ff;
      used_in        = used_ff;
      fresh_in       = fresh_ff;
      enable_in      = csr_we ? csr_wdata : enable_ff;
      rsp_valid_in   = 1'b0;
      rsp_corr_in    = rsp_corr_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_acc_in     = rsp_acc_ff;
      ram_we         = 1'b0;
      ram_wdata      = sv;
      div_start      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_cmd;
               key_in    = req_exposure_us;
               pix_in    = req_pixel_index;
               sample_in = req_sample;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            hit_in     = hit;
            hit_idx_in = hit_idx;
            addr_in    = rd_addr;
            if (cmd_ff == CMD_ACC || cmd_ff == CMD_CORR) begin
               state_in = S_MOD;
            end else begin
               if (cmd_ff == CMD_CLEAR) begin
                  used_in  = '0;
                  fresh_in = 1'b0;
               end
               rsp_valid_in   = 1'b1;
               rsp_corr_in    = '0;
               rsp_matched_in = 1'b0;
               rsp_slot_in    = '0;
               rsp_acc_in     = 1'b0;
               state_in       = S_IDLE;
            end
         end
         S_MOD: begin
            rsp_matched_in = hit_ff;
            rsp_slot_in    = hit_ff ? SLOT_PORT_W'(hit_idx_ff) : '0;
            rsp_acc_in     = 1'b0;
            rsp_corr_in    = '0;
            if (cmd_ff == CMD_CORR) begin
               if (enable_ff && hit_ff && pix_ok) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  rsp_corr_in  = CORR_W'(sample_ff);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               if (enable_ff && pix_ok) begin
                  if (pix_ff == '0) begin
                     if (used_ff >= USED_W'(MAX_SLOTS)) begin
                        fresh_in = 1'b0;
                     end else if (hit_ff) begin
                        if (cur_count < COUNT_MAX) begin
                           counts_in[hit_idx_ff] = cur_count + 1'b1;
                           ram_we     = 1'b1;
                           ram_wdata  = ram_rdata + sv;
                           fresh_in   = 1'b1;
                           rsp_acc_in = 1'b1;
                        end else begin
                           fresh_in = 1'b0;
                        end
                     end else begin
                        keys_in[SLOT_W'(used_ff)]   = key_ff;
                        counts_in[SLOT_W'(used_ff)] = CNT_W'(1);
                        ram_we      = 1'b1;
                        ram_wdata   = sv;
                        used_in     = used_ff + 1'b1;
                        rsp_slot_in = SLOT_PORT_W'(used_ff);
                        fresh_in    = 1'b1;
                        rsp_acc_in  = 1'b1;
                     end
                  end else if (fresh_ff && hit_ff) begin
                     ram_we     = 1'b1;
                     ram_wdata  = (cur_count == CNT_W'(1)) ? sv : ram_rdata + sv;
                     rsp_acc_in = 1'b1;
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               rsp_corr_in  = diff[CORR_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         fresh_ff     <= 1'b0;
         enable_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fresh_ff     <= fresh_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      pix_ff         <= pix_in;
      sample_ff      <= sample_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      addr_ff        <= addr_in;
      keys_ff        <= keys_in;
      counts_ff      <= counts_in;
      rsp_corr_ff    <= rsp_corr_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_acc_ff     <= rsp_acc_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_corrected = rsp_corr_ff;
   assign rsp_matched   = rsp_matched_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_accepted  = rsp_acc_ff;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back to back response strobes");
   a_write_in_mod: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_MOD && cmd_ff == CMD_ACC))
      else $error("sums write outside accumulate");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(MAX_SLOTS))
      else $error("slot count beyond table size");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("beat accepted without going busy");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside divide state");
endmodule
